// ----- hw/rtl/ews_pkg.sv -----
package ews_pkg;

   // register indexes of the control port
   localparam logic CSR_FORMAT = 1'b0;
   localparam logic CSR_ENABLE = 1'b1;

   // output format codes
   localparam logic [3:0] FMT_BIN       = 4'd0;
   localparam logic [3:0] FMT_BIN_TS    = 4'd1;
   localparam logic [3:0] FMT_6B        = 4'd2;
   localparam logic [3:0] FMT_6B_TS     = 4'd3;
   localparam logic [3:0] FMT_6B_NL     = 4'd4;
   localparam logic [3:0] FMT_6B_TS_NL  = 4'd5;
   localparam logic [3:0] FMT_HEX       = 4'd6;
   localparam logic [3:0] FMT_HEX_TS    = 4'd7;
   localparam logic [3:0] FMT_HEX_NL    = 4'd8;
   localparam logic [3:0] FMT_HEX_TS_NL = 4'd9;
   localparam logic [3:0] FMT_ASCII     = 4'd10;
   localparam logic [3:0] FMT_ASCII_TS  = 4'd11;

   localparam int WORD_W = 32;
   localparam int FMT_W  = 4;
   localparam int CSR_W  = 4;
   localparam int IDX_W  = 4;

   // one queued event, already classified
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [FMT_W-1:0]  fmt;
      logic [IDX_W-1:0]  last;
   } entry_type;

   // queue status seen by the two sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // index of the final byte of a run
   function automatic logic [IDX_W-1:0] last_index(input logic [FMT_W-1:0] fmt);
      logic [IDX_W-1:0] r;
      r = '0;
      case (fmt)
         FMT_BIN:       r = 4'd1;
         FMT_BIN_TS:    r = 4'd3;
         FMT_6B:        r = 4'd2;
         FMT_6B_TS:     r = 4'd5;
         FMT_6B_NL:     r = 4'd3;
         FMT_6B_TS_NL:  r = 4'd6;
         FMT_HEX:       r = 4'd3;
         FMT_HEX_TS:    r = 4'd7;
         FMT_HEX_NL:    r = 4'd4;
         FMT_HEX_TS_NL: r = 4'd8;
         FMT_ASCII:     r = 4'd9;
         FMT_ASCII_TS:  r = 4'd15;
         default:       r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/ews_front.sv -----
module ews_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [ews_pkg::WORD_W-1:0] req_event_word,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [ews_pkg::CSR_W-1:0]  csr_wdata,
   input  ews_pkg::qstat_type         q_stat,
   output logic                       q_push,
   output ews_pkg::entry_type         q_wdata
);
   import ews_pkg::*;

   logic [FMT_W-1:0] format_ff, format_in;
   logic             enable_ff, enable_in;
   logic             keep;

   always_comb begin
      format_in = format_ff;
      enable_in = enable_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FORMAT: format_in = csr_wdata[FMT_W-1:0];
            CSR_ENABLE: enable_in = csr_wdata[0];
            default:    format_in = format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_BIN;
         enable_ff <= 1'b0;
      end else begin
         format_ff <= format_in;
         enable_ff <= enable_in;
      end
   end

   // unknown formats and disabled sending drop the word here
   assign keep  = enable_ff && (format_ff <= FMT_ASCII_TS);
   assign full  = q_stat.full;
   assign q_push = push && !q_stat.full && keep;

   always_comb begin
      q_wdata.word = req_event_word;
      q_wdata.fmt  = format_ff;
      q_wdata.last = last_index(format_ff);
   end

endmodule

// ----- hw/rtl/ews_queue.sv -----
module ews_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  ews_pkg::entry_type q_wdata,
   input  logic               q_pop,
   output ews_pkg::entry_type q_rdata,
   output ews_pkg::qstat_type q_stat
);
   import ews_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push = q_push && !q_stat.full;
   assign do_pop  = q_pop && !q_stat.empty;
   assign q_rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= q_wdata;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("word pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("word popped from an empty queue");

endmodule

// ----- hw/rtl/ews_back.sv -----
module ews_back (
   input  logic               clock,
   input  logic               reset,
   input  ews_pkg::qstat_type q_stat,
   input  ews_pkg::entry_type q_rdata,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last_byte
);
   import ews_pkg::*;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam int         TS_DIGITS = 5;

   typedef struct packed {
      logic [3:0] h;
      logic [3:0] t;
      logic [3:0] o;
      logic       h_blank;
      logic       t_blank;
   } dec3_type;

   // 0..127 into three digits, tens by reciprocal multiply
   function automatic dec3_type dec3(input logic [6:0] v);
      dec3_type   d;
      logic [6:0] r;
      logic [14:0] p;
      logic [6:0] t10;
      d.h = (v >= 7'd100) ? 4'd1 : 4'd0;
      r   = (v >= 7'd100) ? v - 7'd100 : v;
      p   = 15'(r) * 15'd205;
      d.t = p[14:11];
      t10 = {d.t, 3'b000} - 7'({d.t, 1'b0}) + 7'({d.t, 2'b00}) ;
      d.o = 4'(r - t10);
      d.h_blank = (d.h == 4'd0);
      d.t_blank = (d.h == 4'd0) && (d.t == 4'd0);
      return d;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? CH_ZERO + 8'(n) : 8'h37 + 8'(n);
   endfunction

   function automatic logic [7:0] dig_char(input logic [3:0] n, input logic blank);
      return blank ? CH_SPACE : CH_ZERO + 8'(n);
   endfunction

   // current event
   logic [WORD_W-1:0] word_ff, word_in;
   logic [FMT_W-1:0]  fmt_ff, fmt_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              active_ff, active_in;

   // timestamp conversion, lowest digit first
   logic [15:0]       rem_ff, rem_in;
   logic [2:0]        step_ff, step_in;
   logic [3:0]        tsd_ff [TS_DIGITS];
   logic              tsb_ff [TS_DIGITS];
   logic [31:0]       prod;
   logic [15:0]       quot;
   logic [3:0]        digit;
   logic              ts_done;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff;
   logic              out_last_ff;

   logic              slot_free, ts_wait, issue, issue_last, load;
   logic [7:0]        next_byte;
   dec3_type          xd, yd;

   assign slot_free  = !out_valid_ff || pop;
   assign ts_done    = (step_ff == 3'(TS_DIGITS));
   assign ts_wait    = (fmt_ff == FMT_ASCII_TS) && (idx_ff >= 4'd10) && (idx_ff <= 4'd14)
                       && !ts_done;
   assign issue      = active_ff && slot_free && !ts_wait;
   assign issue_last = issue && (idx_ff == last_ff);
   assign load       = !q_stat.empty && (!active_ff || issue_last);
   assign q_pop      = load;

   always_comb begin
      word_in   = word_ff;
      fmt_in    = fmt_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (issue) begin
         idx_in = idx_ff + 1'b1;
         if (issue_last)
            active_in = 1'b0;
      end
      if (load) begin
         word_in   = q_rdata.word;
         fmt_in    = q_rdata.fmt;
         last_in   = q_rdata.last;
         idx_in    = '0;
         active_in = 1'b1;
      end
   end

   // divide by ten: exact for 16-bit values with 0xCCCD >> 19
   assign prod  = rem_ff * 32'h0000CCCD;
   assign quot  = 16'(prod[31:19]);
   assign digit = 4'(rem_ff - ({quot[12:0], 3'b000} + {quot[14:0], 1'b0}));

   always_comb begin
      rem_in  = rem_ff;
      step_in = step_ff;
      if (load) begin
         rem_in  = q_rdata.word[15:0];
         step_in = '0;
      end else if (!ts_done) begin
         rem_in  = quot;
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!load && !ts_done) begin
         for (int i = 0; i < TS_DIGITS; i++) begin
            if (step_ff == 3'(i)) begin
               tsd_ff[i] <= digit;
               tsb_ff[i] <= (i != 0) && (rem_ff == '0);
            end
         end
      end
   end

   assign xd = dec3(word_ff[30:24]);
   assign yd = dec3(word_ff[22:16]);

   // byte for the current position of the run
   always_comb begin
      next_byte = CH_NL;
      case (fmt_ff)
         FMT_BIN, FMT_BIN_TS: begin
            case (idx_ff[1:0])
               2'd0:    next_byte = word_ff[31:24];
               2'd1:    next_byte = word_ff[23:16];
               2'd2:    next_byte = word_ff[15:8];
               default: next_byte = word_ff[7:0];
            endcase
         end
         FMT_6B, FMT_6B_NL: begin
            case (idx_ff)
               4'd0:    next_byte = 8'({4'b0000, word_ff[31:28]}) + 8'd32;
               4'd1:    next_byte = 8'({2'b00, word_ff[27:22]}) + 8'd32;
               4'd2:    next_byte = 8'({2'b00, word_ff[21:16]}) + 8'd32;
               default: next_byte = CH_NL;
            endcase
         end
         FMT_6B_TS, FMT_6B_TS_NL: begin
            case (idx_ff)
               4'd0:    next_byte = 8'({6'b000000, word_ff[31:30]}) + 8'd32;
               4'd1:    next_byte = 8'({2'b00, word_ff[29:24]}) + 8'd32;
               4'd2:    next_byte = 8'({2'b00, word_ff[23:18]}) + 8'd32;
               4'd3:    next_byte = 8'({2'b00, word_ff[17:12]}) + 8'd32;
               4'd4:    next_byte = 8'({2'b00, word_ff[11:6]}) + 8'd32;
               4'd5:    next_byte = 8'({2'b00, word_ff[5:0]}) + 8'd32;
               default: next_byte = CH_NL;
            endcase
         end
         FMT_HEX, FMT_HEX_NL, FMT_HEX_TS, FMT_HEX_TS_NL: begin
            if (idx_ff == last_ff && (fmt_ff == FMT_HEX_NL || fmt_ff == FMT_HEX_TS_NL))
               next_byte = CH_NL;
            else begin
               case (idx_ff[2:0])
                  3'd0:    next_byte = hex_char(word_ff[31:28]);
                  3'd1:    next_byte = hex_char(word_ff[27:24]);
                  3'd2:    next_byte = hex_char(word_ff[23:20]);
                  3'd3:    next_byte = hex_char(word_ff[19:16]);
                  3'd4:    next_byte = hex_char(word_ff[15:12]);
                  3'd5:    next_byte = hex_char(word_ff[11:8]);
                  3'd6:    next_byte = hex_char(word_ff[7:4]);
                  default: next_byte = hex_char(word_ff[3:0]);
               endcase
            end
         end
         FMT_ASCII, FMT_ASCII_TS: begin
            case (idx_ff)
               4'd0:    next_byte = CH_ZERO + 8'(word_ff[23]);
               4'd1:    next_byte = CH_SPACE;
               4'd2:    next_byte = dig_char(xd.h, xd.h_blank);
               4'd3:    next_byte = dig_char(xd.t, xd.t_blank);
               4'd4:    next_byte = dig_char(xd.o, 1'b0);
               4'd5:    next_byte = CH_SPACE;
               4'd6:    next_byte = dig_char(yd.h, yd.h_blank);
               4'd7:    next_byte = dig_char(yd.t, yd.t_blank);
               4'd8:    next_byte = dig_char(yd.o, 1'b0);
               4'd9:    next_byte = (fmt_ff == FMT_ASCII_TS) ? CH_SPACE : CH_NL;
               4'd10:   next_byte = dig_char(tsd_ff[4], tsb_ff[4]);
               4'd11:   next_byte = dig_char(tsd_ff[3], tsb_ff[3]);
               4'd12:   next_byte = dig_char(tsd_ff[2], tsb_ff[2]);
               4'd13:   next_byte = dig_char(tsd_ff[1], tsb_ff[1]);
               4'd14:   next_byte = dig_char(tsd_ff[0], tsb_ff[0]);
               default: next_byte = CH_NL;
            endcase
         end
         default: next_byte = CH_NL;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (issue)
         out_valid_in = 1'b1;
      else if (pop)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         step_ff      <= 3'(TS_DIGITS);
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      fmt_ff  <= fmt_in;
      last_ff <= last_in;
      rem_ff  <= rem_in;
      if (issue) begin
         out_byte_ff <= next_byte;
         out_last_ff <= issue_last;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_tx_byte   = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= last_ff))
      else $error("byte position past end of run");

   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      load |=> (active_ff && idx_ff == '0 && step_ff == '0))
      else $error("new event did not restart the run");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'(TS_DIGITS))
      else $error("timestamp conversion ran past its digits");

endmodule

// ----- hw/rtl/event_word_serializer_core.sv -----
// path: a first byte reaches the result ports through the queue slot, the event register
//    of the back end and the output register, when the queue and the back end are idle
// throughput: one byte per cycle unless pop stalls; an event gives 2 to 16 bytes (16 for
//    ascii with timestamp), the next event's first byte follows its last with no gap
// reset: synchronous, clears format to binary, sending off, empties the queue and output
module event_word_serializer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // word input, queue style
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_event_word,
   // byte output, queue style
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   // control registers
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import ews_pkg::*;

   // front to queue
   logic      q_push;
   entry_type q_wdata;
   // queue to back
   logic      q_pop;
   entry_type q_rdata;
   qstat_type q_stat;

   // front: control registers, drops words that produce nothing and sizes the run
   ews_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_event_word (req_event_word),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_wdata        (q_wdata)
   );

   // short queue of classified words, lets the input run ahead of the byte stream
   ews_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_stat  (q_stat)
   );

   // back: byte sequencer with timestamp-to-decimal unit and output register
   ews_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_rdata       (q_rdata),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
